[src/gtd_pkg.sv]
package gtd_pkg;

  localparam int MAX_BLOCK_DEF = 4096;
  localparam int ADC_BITS_DEF  = 12;
  localparam int SAMPLE_W      = 12;
  localparam int STATE_W       = 48;
  localparam int FRAC_BITS     = 14;
  localparam int LEN_W         = 16;
  localparam int MAG_W         = 20;

  localparam logic [1:0] CFG_COEFF = 2'd0;
  localparam logic [1:0] CFG_BLEN  = 2'd1;
  localparam logic [1:0] CFG_DC    = 2'd2;

  typedef struct packed {
    logic signed [15:0] coeff;
    logic [12:0]        blen;
    logic [11:0]        dc;
  } gtd_cfg_t;

  // one finished block handed from the front to the back
  typedef struct packed {
    logic signed [STATE_W-1:0] s1;
    logic signed [STATE_W-1:0] s2;
    logic [LEN_W-1:0]          n;
  } gtd_job_t;

endpackage

[src/gtd_front.sv]
module gtd_front #(
  parameter int MAX_BLOCK = gtd_pkg::MAX_BLOCK_DEF,
  parameter int ADC_BITS  = gtd_pkg::ADC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  gtd_pkg::gtd_cfg_t                  cfg_i,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [gtd_pkg::SAMPLE_W-1:0]       in_sample,
  input  logic                               full_i,
  output logic                               push_o,
  output gtd_pkg::gtd_job_t                  job_o
);
  import gtd_pkg::*;

  localparam int CNT_W = $clog2(MAX_BLOCK + 1);

  logic signed [STATE_W-1:0] d1_r, d1_nxt, d2_r, d2_nxt;
  logic [CNT_W-1:0]          seen_r, seen_nxt;
  logic [SAMPLE_W-1:0]       raw;
  logic signed [12:0]        x;
  logic signed [63:0]        prod;
  logic signed [51:0]        s_wide;
  logic signed [STATE_W-1:0] s_sat;
  logic [LEN_W-1:0]          n_eff;
  logic                      done, acc;

  always_comb begin
    for (int i = 0; i < SAMPLE_W; i++) begin
      raw[i] = in_sample[i] & (i < ADC_BITS);
    end
  end

  assign x    = $signed({1'b0, raw}) - $signed({1'b0, cfg_i.dc});
  assign prod = cfg_i.coeff * d1_r;
  assign s_wide = $signed({{25{x[12]}}, x, 14'b0})
                + $signed({{2{prod[63]}}, prod[63:FRAC_BITS]})
                - $signed({{4{d2_r[STATE_W-1]}}, d2_r});

  // clamp to the 48-bit state range
  always_comb begin
    if (s_wide[51:47] == 5'b00000 || s_wide[51:47] == 5'b11111) begin
      s_sat = s_wide[STATE_W-1:0];
    end else if (s_wide[51]) begin
      s_sat = {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      s_sat = {1'b0, {(STATE_W-1){1'b1}}};
    end
  end

  always_comb begin
    if (cfg_i.blen == 13'd0) begin
      n_eff = LEN_W'(1);
    end else if (32'(cfg_i.blen) > 32'(MAX_BLOCK)) begin
      n_eff = LEN_W'(MAX_BLOCK);
    end else begin
      n_eff = LEN_W'(cfg_i.blen);
    end
  end

  assign done      = ({1'b0, LEN_W'(seen_r)} + 17'd1) >= {1'b0, n_eff};
  assign in_tready = !full_i;
  assign acc       = in_tvalid && in_tready;
  assign push_o    = acc && done;
  assign job_o     = '{s1: s_sat, s2: d1_r, n: n_eff};

  always_comb begin
    d1_nxt   = d1_r;
    d2_nxt   = d2_r;
    seen_nxt = seen_r;
    if (acc) begin
      if (done) begin
        d1_nxt   = '0;
        d2_nxt   = '0;
        seen_nxt = '0;
      end else begin
        d1_nxt   = s_sat;
        d2_nxt   = d1_r;
        seen_nxt = seen_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r   <= '0;
      d2_r   <= '0;
      seen_r <= '0;
    end else begin
      d1_r   <= d1_nxt;
      d2_r   <= d2_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule

[src/gtd_queue.sv]
module gtd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  input  gtd_pkg::gtd_job_t job_i,
  output logic              full_o,
  input  logic              pop_i,
  output gtd_pkg::gtd_job_t job_o,
  output logic              empty_o
);
  import gtd_pkg::*;

  gtd_job_t   ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full_o  = (cnt_r == 2'd2);
  assign empty_o = (cnt_r == 2'd0);
  assign job_o   = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push_i) begin
      ent_r[wp_r] <= job_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_i) wp_r <= !wp_r;
      if (pop_i)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push_i) - 2'(pop_i);
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !empty_o) else $error("queue pop while empty");
`endif

endmodule

[src/gtd_back.sv]
module gtd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [15:0] coeff_i,
  input  gtd_pkg::gtd_job_t  job_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [39:0]        out_tdata
);
  import gtd_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL  = 4'd1;
  localparam logic [3:0] ST_ACC  = 4'd2;
  localparam logic [3:0] ST_EN   = 4'd3;
  localparam logic [3:0] ST_SQ   = 4'd4;
  localparam logic [3:0] ST_DV0  = 4'd5;
  localparam logic [3:0] ST_DV   = 4'd6;
  localparam logic [3:0] ST_SM   = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;

  logic [3:0]   st_r, st_nxt;
  logic [5:0]   cnt_r, cnt_nxt;
  logic [47:0]  a1_r, a1_nxt, a2_r, a2_nxt;
  logic [15:0]  cm_r, cm_nxt;
  logic         neg_r, neg_nxt;
  logic [15:0]  n_r, n_nxt;
  logic [111:0] s_r, s_nxt, p_r, p_nxt;
  logic [63:0]  ca_r, ca_nxt;
  logic [47:0]  prod_r, prod_nxt;
  logic [111:0] rad_r, rad_nxt;
  logic [59:0]  rem_r, rem_nxt;
  logic [55:0]  root_r, root_nxt;
  logic [15:0]  drem_r, drem_nxt;
  logic [19:0]  dnum_r, dnum_nxt, q_r, q_nxt;
  logic [55:0]  sprod_r, sprod_nxt;
  logic [19:0]  smooth_r, smooth_nxt;
  logic         ov_r, ov_nxt;
  logic [39:0]  od_r, od_nxt;

  logic [3:0]   step;
  logic [2:0]   idx;
  logic [23:0]  opa, opb;
  logic [1:0]   sh;
  logic [111:0] shv, sh14;
  logic [59:0]  rem_sh, trial;
  logic [43:0]  num;
  logic [16:0]  drem_sh;
  logic [23:0]  v;

  function automatic logic [23:0] chunk48(logic [47:0] a, logic k);
    return k ? a[47:24] : a[23:0];
  endfunction

  assign step = cnt_r[3:0];
  assign idx  = 3'(step - 4'd10);

  // operand schedule of the shared 24x24 multiplier
  always_comb begin
    if (step < 4'd8) begin
      opa = chunk48(step[2] ? a2_r : a1_r, step[1]);
      opb = chunk48(step[2] ? a2_r : a1_r, step[0]);
      sh  = 2'(step[1]) + 2'(step[0]);
    end else if (step < 4'd10) begin
      opa = {8'b0, cm_r};
      opb = chunk48(a1_r, step[0]);
      sh  = 2'(step[0]);
    end else begin
      unique case (idx[2:1])
        2'd0:    opa = ca_r[23:0];
        2'd1:    opa = ca_r[47:24];
        default: opa = {8'b0, ca_r[63:48]};
      endcase
      opb = chunk48(a2_r, idx[0]);
      sh  = idx[2:1] + 2'(idx[0]);
    end
  end

  always_comb begin
    unique case (sh)
      2'd0: shv = {64'b0, prod_r};
      2'd1: shv = {40'b0, prod_r, 24'b0};
      2'd2: shv = {16'b0, prod_r, 48'b0};
      2'd3: shv = {prod_r[39:0], 72'b0};
    endcase
  end

  assign sh14    = {s_r[97:0], 14'b0};
  assign rem_sh  = {rem_r[57:0], rad_r[111:110]};
  assign trial   = {2'b0, root_r, 2'b01};
  assign num     = root_r[55:12];
  assign drem_sh = {drem_r, dnum_r[19]};
  assign v       = 24'(q_r) * 24'd3 + 24'(smooth_r) * 24'd7 + 24'd5;

  assign pop_o      = (st_r == ST_IDLE) && !empty_i;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  always_comb begin
    st_nxt     = st_r;
    cnt_nxt    = cnt_r;
    a1_nxt     = a1_r;
    a2_nxt     = a2_r;
    cm_nxt     = cm_r;
    neg_nxt    = neg_r;
    n_nxt      = n_r;
    s_nxt      = s_r;
    p_nxt      = p_r;
    ca_nxt     = ca_r;
    prod_nxt   = prod_r;
    rad_nxt    = rad_r;
    rem_nxt    = rem_r;
    root_nxt   = root_r;
    drem_nxt   = drem_r;
    dnum_nxt   = dnum_r;
    q_nxt      = q_r;
    sprod_nxt  = sprod_r;
    smooth_nxt = smooth_r;
    ov_nxt     = ov_r;
    od_nxt     = od_r;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (!empty_i) begin
          a1_nxt  = job_i.s1[47] ? (~job_i.s1 + 48'd1) : job_i.s1;
          a2_nxt  = job_i.s2[47] ? (~job_i.s2 + 48'd1) : job_i.s2;
          cm_nxt  = coeff_i[15] ? (~coeff_i + 16'd1) : coeff_i;
          neg_nxt = (coeff_i[15] ^ job_i.s1[47] ^ job_i.s2[47]) && (coeff_i != 16'sd0)
                    && (job_i.s1 != 48'sd0) && (job_i.s2 != 48'sd0);
          n_nxt   = job_i.n;
          s_nxt   = '0;
          p_nxt   = '0;
          ca_nxt  = '0;
          cnt_nxt = '0;
          st_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt = opa * opb;
        st_nxt   = ST_ACC;
      end
      ST_ACC: begin
        if (step < 4'd8) begin
          s_nxt = s_r + shv;
        end else if (step < 4'd10) begin
          ca_nxt = ca_r + shv[63:0];
        end else begin
          p_nxt = p_r + shv;
        end
        cnt_nxt = cnt_r + 6'd1;
        st_nxt  = (step == 4'd15) ? ST_EN : ST_MUL;
      end
      ST_EN: begin
        if (neg_r) begin
          rad_nxt = sh14 + p_r;
        end else if (p_r <= sh14) begin
          rad_nxt = sh14 - p_r;
        end else begin
          rad_nxt = '0;
        end
        rem_nxt  = '0;
        root_nxt = '0;
        cnt_nxt  = '0;
        st_nxt   = ST_SQ;
      end
      ST_SQ: begin
        // two radicand bits per step, one root bit out
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {root_r[54:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_r[54:0], 1'b0};
        end
        rad_nxt = {rad_r[109:0], 2'b00};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd55) st_nxt = ST_DV0;
      end
      ST_DV0: begin
        if (num >= ({28'b0, n_r} << 20)) begin
          q_nxt  = {MAG_W{1'b1}};
          st_nxt = ST_SM;
        end else begin
          drem_nxt = num[35:20];
          dnum_nxt = num[19:0];
          q_nxt    = '0;
          cnt_nxt  = '0;
          st_nxt   = ST_DV;
        end
      end
      ST_DV: begin
        if (drem_sh >= {1'b0, n_r}) begin
          drem_nxt = 16'(drem_sh - {1'b0, n_r});
          q_nxt    = {q_r[18:0], 1'b1};
        end else begin
          drem_nxt = drem_sh[15:0];
          q_nxt    = {q_r[18:0], 1'b0};
        end
        dnum_nxt = {dnum_r[18:0], 1'b0};
        cnt_nxt  = cnt_r + 6'd1;
        if (cnt_r == 6'd19) st_nxt = ST_SM;
      end
      ST_SM: begin
        sprod_nxt = v * RECIP10;
        st_nxt    = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register frees up
        if (!ov_r || out_tready) begin
          od_nxt     = {sprod_r[54:35], q_r};
          smooth_nxt = sprod_r[54:35];
          ov_nxt     = 1'b1;
          st_nxt     = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    a1_r    <= a1_nxt;
    a2_r    <= a2_nxt;
    cm_r    <= cm_nxt;
    neg_r   <= neg_nxt;
    n_r     <= n_nxt;
    s_r     <= s_nxt;
    p_r     <= p_nxt;
    ca_r    <= ca_nxt;
    prod_r  <= prod_nxt;
    rad_r   <= rad_nxt;
    rem_r   <= rem_nxt;
    root_r  <= root_nxt;
    drem_r  <= drem_nxt;
    dnum_r  <= dnum_nxt;
    q_r     <= q_nxt;
    sprod_r <= sprod_nxt;
    od_r    <= od_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      cnt_r    <= '0;
      smooth_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      cnt_r    <= cnt_nxt;
      smooth_r <= smooth_nxt;
      ov_r     <= ov_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DV) |-> (drem_r < n_r)) else $error("divider remainder out of range");
`endif

endmodule

[src/goertzel_tone_detector.sv]
// Goertzel single-bin tone detector.
// Samples: one accepted per cycle while the block queue has room; the
// recurrence (16x48 multiply and add) updates in the accepting cycle.
// Results: after the last sample of a block the back end runs an energy
// sequence on a shared 24x24 multiplier, a square root, a divide and
// smoothing; the back end takes one block at a time.
// Reset (rst_n, synchronous, active low) clears the state and loads the registers.
module goertzel_tone_detector #(
  parameter int MAX_BLOCK = gtd_pkg::MAX_BLOCK_DEF,
  parameter int ADC_BITS  = gtd_pkg::ADC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] adc_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [19:0] magnitude, [39:20] smoothed_magnitude
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import gtd_pkg::*;

  gtd_cfg_t cfg_r;
  gtd_job_t push_job, pop_job;
  logic     push, pop, full, empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coeff <= 16'sd0;
      cfg_r.blen  <= 13'd400;
      cfg_r.dc    <= 12'd2048;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_COEFF: cfg_r.coeff <= $signed(cfg_wdata);
        CFG_BLEN:  cfg_r.blen  <= cfg_wdata[12:0];
        CFG_DC:    cfg_r.dc    <= cfg_wdata[11:0];
        default:   ;
      endcase
    end
  end

  gtd_front #(.MAX_BLOCK(MAX_BLOCK), .ADC_BITS(ADC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_i     (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_sample (in_tdata[SAMPLE_W-1:0]),
    .full_i    (full),
    .push_o    (push),
    .job_o     (push_job)
  );

  gtd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (pop_job),
    .empty_o (empty)
  );

  gtd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .coeff_i    (cfg_r.coeff),
    .job_i      (pop_job),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[sim/goertzel_tone_detector_tb.sv]
class tone_ledger;
  // register copy
  logic signed [15:0] coeff;
  logic [12:0]        blen;
  logic [11:0]        dc;
  // recurrence copy
  logic signed [47:0] delay_a;
  logic signed [47:0] delay_b;
  int unsigned        taken;
  logic [19:0]        smooth;

  logic [19:0] mag_q[$];
  logic [19:0] smooth_q[$];
  int          errors;
  int          blocks_done;

  function new();
    coeff = 16'sd0;
    blen = 13'd400;
    dc = 12'd2048;
    delay_a = '0;
    delay_b = '0;
    taken = 0;
    smooth = '0;
    errors = 0;
    blocks_done = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [15:0] val);
    case (idx)
      gtd_pkg::CFG_COEFF: coeff = val;
      gtd_pkg::CFG_BLEN:  blen = val[12:0];
      gtd_pkg::CFG_DC:    dc = val[11:0];
      default: ;
    endcase
  endfunction

  // amplitude of the finished block in Q11.9
  function logic [19:0] block_amplitude(int unsigned n);
    logic signed [127:0] s1, s2, c, energy;
    logic [127:0] e, root, cand, q;
    s1 = delay_a;
    s2 = delay_b;
    c = coeff;
    energy = ((s1 * s1 + s2 * s2) <<< 14) - c * s1 * s2;
    e = (energy < 0) ? '0 : energy;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= e) root = cand;
    end
    q = root / (128'(n) << 12);
    return (q > 128'hFFFFF) ? 20'hFFFFF : q[19:0];
  endfunction

  function void take_sample(logic [11:0] sample);
    longint signed x, prod, s;
    int unsigned n;
    logic [19:0] mag;
    n = blen;
    if (n == 0) n = 1;
    if (n > 4096) n = 4096;
    x = longint'(sample) - longint'(dc);
    prod = longint'(coeff) * longint'(delay_a);
    s = (x <<< 14) + (prod >>> 14) - longint'(delay_b);
    if (s > 64'sh7FFF_FFFF_FFFF) s = 64'sh7FFF_FFFF_FFFF;
    if (s < -64'sh8000_0000_0000) s = -64'sh8000_0000_0000;
    delay_b = delay_a;
    delay_a = s[47:0];
    taken++;
    if (taken < n) return;
    mag = block_amplitude(n);
    smooth = (3 * 64'(mag) + 7 * 64'(smooth) + 5) / 10;
    mag_q.push_back(mag);
    smooth_q.push_back(smooth);
    delay_a = '0;
    delay_b = '0;
    taken = 0;
  endfunction

  function void match_result(logic [39:0] data);
    logic [19:0] em, es;
    if (mag_q.size() == 0) begin
      $error("unexpected result transaction %h", data);
      errors++;
      return;
    end
    em = mag_q.pop_front();
    es = smooth_q.pop_front();
    blocks_done++;
    if (data[19:0] !== em) begin
      $error("magnitude: expected %0d, actual %0d", em, data[19:0]);
      errors++;
    end
    if (data[39:20] !== es) begin
      $error("smoothed_magnitude: expected %0d, actual %0d", es, data[39:20]);
      errors++;
    end
  endfunction
endclass

module goertzel_tone_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = gtd_pkg::CFG_COEFF;
  logic [15:0] cfg_wdata = '0;

  tone_ledger ledger = new();
  int   stall_mode = 0;  // 0 none, 1 receiver heavy, 2 sender heavy
  int   cycles = 0;
  int   samples_sent = 0;

  goertzel_tone_detector uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    case (stall_mode)
      1: out_tready <= $urandom_range(99) >= 55;
      2: out_tready <= $urandom_range(99) >= 8;
      default: out_tready <= 1'b1;
    endcase
    if (rst_n && out_tvalid && out_tready) ledger.match_result(out_tdata);
  end

  task automatic send_sample(logic [11:0] v);
    int gap_pct;
    gap_pct = (stall_mode == 1) ? 8 : (stall_mode == 2) ? 55 : 0;
    if ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'h0, v};
    do @(posedge clk); while (!in_tready);
    ledger.take_sample(v);
    samples_sent++;
  endtask

  // drop valid, wait for every block to come back, let the back end settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (ledger.mag_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(logic [15:0] c, logic [15:0] b, logic [15:0] d);
    logic [1:0]  idx[4];
    logic [15:0] val[4];
    idx = '{gtd_pkg::CFG_COEFF, gtd_pkg::CFG_BLEN, gtd_pkg::CFG_DC, 2'd3};
    val = '{c, b, d, 16'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      ledger.write_reg(idx[i], val[i]);
    end
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int random_sent;
    int count;
    int kind;
    logic [15:0] c, b, d;
    logic [11:0] v;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers, a few samples into a 400-long block
    send_sample(12'h000);
    send_sample(12'hFFF);
    send_sample(12'hA5A);
    drain();
    // single-sample blocks at the sample extremes
    configure(16'h7FFF, 16'd1, 16'd0);
    send_sample(12'h000);
    send_sample(12'hFFF);
    send_sample(12'h5A5);
    drain();
    // zero length acts as one
    configure(16'h8000, 16'd0, 16'd4095);
    send_sample(12'h000);
    send_sample(12'hFFF);
    drain();
    // length lowered while a block is partly filled
    configure(16'h4000, 16'd10, 16'd2048);
    repeat (6) send_sample(12'($urandom));
    drain();
    configure(16'h4000, 16'd3, 16'd2048);
    send_sample(12'h123);
    send_sample(12'hFED);
    drain();
    // oversized length clips to the maximum and holds the block open;
    // a shorter length then ends it on the next sample
    configure(16'h8000, 16'h1FFF, 16'd2048);
    for (int i = 0; i < 40; i++) send_sample((i % 2) ? 12'hFFF : 12'h000);
    drain();
    configure(16'h8000, 16'd20, 16'd2048);
    send_sample(12'hFFF);
    drain();

    random_sent = 0;
    while (random_sent < 1450) begin
      stall_mode = (random_sent < 480) ? 1 : (random_sent < 960) ? 2 : 0;
      kind = $urandom_range(9);
      c = (kind == 0) ? 16'h7FFF : (kind == 1) ? 16'h8000 : 16'($urandom);
      kind = $urandom_range(39);
      b = (kind == 0) ? 16'($urandom_range(600, 300)) : (kind == 1) ? 16'd0 :
          16'($urandom_range(32, 1));
      if ($urandom_range(7) == 0) b[15:13] = 3'($urandom);
      kind = $urandom_range(9);
      d = (kind == 0) ? 16'd0 : (kind == 1) ? 16'd4095 :
          (kind < 5) ? 16'd2048 : 16'($urandom_range(4095));
      configure(c, b, d);
      count = $urandom_range(120, 20);
      kind = $urandom_range(5);
      for (int i = 0; i < count; i++) begin
        case (kind)
          0: v = (i % 2) ? 12'hFFF : 12'h000;
          1: v = ((i / 4) % 2) ? 12'hFFF : 12'h000;
          default: v = 12'($urandom);
        endcase
        send_sample(v);
        random_sent++;
      end
      drain();
    end
    stall_mode = 0;
    drain();

    $display("run covered %0d samples and %0d finished blocks", samples_sent,
             ledger.blocks_done);
    $display("register sets included coefficient and length extremes, zero and oversized"
             );
    if (ledger.errors == 0 && ledger.mag_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

[files.f]
src/gtd_pkg.sv
src/gtd_front.sv
src/gtd_queue.sv
src/gtd_back.sv
src/goertzel_tone_detector.sv
sim/goertzel_tone_detector_tb.sv
